// File: design/czs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czs_pkg
// Shared types, constants and rounding, saturation and clamping helpers of the zoom smoother.
// ----------------------------------------------------------------------------
package czs_pkg;

	// arithmetic unit widths
	localparam int DIV_W  = 44;
	localparam int DIV_CW = 6;
	localparam int MUL_AW = 48;
	localparam int MUL_BW = 32;
	localparam int MUL_HW = 24;
	localparam int PROD_W = 64;

	// fixed-point constants
	localparam logic [15:0] MIN_FLOOR = 16'd26;
	localparam logic signed [MUL_BW-1:0] C048  = 32'sd31457;
	localparam logic signed [MUL_BW-1:0] C0235 = 32'sd15401;
	localparam logic signed [PROD_W-1:0] X_CAP   = 64'sd67108864;
	localparam logic signed [PROD_W-1:0] T_LIM   = 64'sd4294967296;
	localparam logic signed [PROD_W-1:0] N_LIM   = 64'sd274877906944;
	localparam logic signed [PROD_W-1:0] VN_HI   = 64'sd8388607;
	localparam logic signed [PROD_W-1:0] VN_LO   = -64'sd8388608;
	localparam logic signed [PROD_W-1:0] ONE_Q16 = 64'sd65536;
	localparam logic [DIV_W-1:0] W_NUM = 44'd536870912;
	localparam logic [DIV_W-1:0] E_NUM = 44'd1099511627776;

	// configuration register indexes
	localparam logic [1:0] CFG_MIN    = 2'd0;
	localparam logic [1:0] CFG_MAX    = 2'd1;
	localparam logic [1:0] CFG_START  = 2'd2;
	localparam logic [1:0] CFG_SMOOTH = 2'd3;

	// datapath operations, in sequence order
	typedef enum logic [3:0] {
		OP_GOAL,
		OP_W,
		OP_X,
		OP_X2,
		OP_X3,
		OP_K1,
		OP_DEN,
		OP_E,
		OP_S,
		OP_T,
		OP_N,
		OP_VN,
		OP_O
	} czs_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GOAL,
		S_RUN,
		S_FIN
	} czs_state_t;

	typedef struct packed {
		logic    load;
		logic    go;
		logic    capture;
		logic    finish;
		czs_op_t op;
	} czs_cmd_t;

	typedef struct packed {
		logic unit_done;
		logic st_zero;
		logic out_full;
	} czs_stat_t;

	// shift right with rounding half away from zero
	function automatic logic signed [PROD_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] a,
			input int unsigned sh);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = a[PROD_W-1] ? PROD_W'(-a) : PROD_W'(a);
		r = (mag + (64'd1 << (sh - 1))) >> sh;
		return a[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

	// symmetric saturation
	function automatic logic signed [PROD_W-1:0] sat_sym(input logic signed [PROD_W-1:0] a,
			input logic signed [PROD_W-1:0] lim);
		if (a > lim)
			return lim;
		if (a < -lim)
			return -lim;
		return a;
	endfunction

	// clamp into an unsigned 16 bit range
	function automatic logic [15:0] clamp_rng(input logic signed [PROD_W-1:0] a,
			input logic [15:0] lo, input logic [15:0] hi);
		if (a < $signed({48'd0, lo}))
			return lo;
		if (a > $signed({48'd0, hi}))
			return hi;
		return a[15:0];
	endfunction

endpackage

// File: design/critically_damped_zoom_smoother_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// critically_damped_zoom_smoother_unit
// Critically damped smooth-damp zoom filter with range clamping.
// ----------------------------------------------------------------------------
// Each input word carries a signed Q8.8 zoom step and a Q0.16 time step; one
// output word with the smoothed size and the clamped goal follows for each.
// One word is processed at a time. With a nonzero smoothing time each word
// steps through accept, goal update, two passes of the shared restoring
// divider (the 2/T rate and the damping factor, each a start, 44 quotient
// bits and a capture), ten products on the shared split multiplier, and
// output. With a zero smoothing time the goal update goes straight to output.
// A finished word waits in the output register while the next input word is
// taken; a word still waiting there stalls the finish of the following one.
module critically_damped_zoom_smoother_unit
	import czs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] zoom_step, [31:16] time_step
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] size_now, [31:16] size_goal
);

	czs_cmd_t  cmd;
	czs_stat_t stat;

	czs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	czs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: design/czs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module czs_div
	import czs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic [DIV_W-1:0] quo,
	output logic             done
);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic              fits;

	// shift in next numerator bit and try the subtract
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CW'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// File: design/czs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czs_mul
// Signed multiplier, wide operand split in two halves.
// ----------------------------------------------------------------------------
module czs_mul
	import czs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [MUL_AW-1:0] a,
	input  logic signed [MUL_BW-1:0] b,
	output logic signed [PROD_W-1:0] p,
	output logic                     done
);

	logic signed [MUL_AW-1:0]          a_q;
	logic signed [MUL_BW-1:0]          b_q;
	logic [1:0]                        phase_q;
	logic                              done_q;
	logic signed [MUL_HW+MUL_BW:0]     lo_q;
	logic signed [MUL_HW+MUL_BW-1:0]   hi_q;
	logic signed [PROD_W-1:0]          p_q;

	// phase sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start)
				phase_q <= 2'd1;
			else if (phase_q != '0) begin
				phase_q <= phase_q + 1'b1;
				if (phase_q == 2'd3)
					done_q <= 1'b1;
			end
		end
	end

	// low half, high half, then sum
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (phase_q == 2'd1)
			lo_q <= $signed({1'b0, a_q[MUL_HW-1:0]}) * b_q;
		if (phase_q == 2'd2)
			hi_q <= $signed(a_q[MUL_AW-1:MUL_HW]) * b_q;
		if (phase_q == 2'd3)
			p_q <= (PROD_W'(hi_q) <<< MUL_HW) + PROD_W'(lo_q);
	end

	assign p    = p_q;
	assign done = done_q;

endmodule

// File: design/czs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czs_ctrl
// Sequencer that steps the datapath through one smoothing update.
// ----------------------------------------------------------------------------
module czs_ctrl
	import czs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  czs_stat_t stat,
	output czs_cmd_t  cmd
);

	czs_state_t state_q, state_n;
	czs_op_t    op_q, op_n;
	logic       busy_q, busy_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_W;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
			busy_q  <= busy_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n     = state_q;
		op_n        = op_q;
		busy_n      = busy_q;
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.go      = 1'b0;
		cmd.capture = 1'b0;
		cmd.finish  = 1'b0;
		cmd.op      = op_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_n  = S_GOAL;
				end
			end
			S_GOAL: begin
				cmd.capture = 1'b1;
				cmd.op      = OP_GOAL;
				op_n        = OP_W;
				busy_n      = 1'b0;
				state_n     = stat.st_zero ? S_FIN : S_RUN;
			end
			S_RUN: begin
				if (!busy_q) begin
					cmd.go = 1'b1;
					busy_n = 1'b1;
				end else if (stat.unit_done) begin
					cmd.capture = 1'b1;
					busy_n      = 1'b0;
					if (op_q == OP_O)
						state_n = S_FIN;
					else
						op_n = czs_op_t'(op_q + 1'b1);
				end
			end
			S_FIN: begin
				if (!stat.out_full) begin
					cmd.finish = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

endmodule

// File: design/czs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czs_dp
// Datapath: configuration, state, step registers, shared divider and multiplier.
// ----------------------------------------------------------------------------
module czs_dp
	import czs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	input  czs_cmd_t    cmd,
	output czs_stat_t   stat
);

	// configuration
	logic [15:0] min_q, max_q, start_q;
	logic [12:0] st_q;
	// item and persistent state
	logic signed [15:0] zoom_q;
	logic [15:0]        ts_q;
	logic [15:0]        size_q, goal_q;
	logic signed [23:0] speed_q;
	logic               started_q;
	// step values
	logic [29:0]        w_q;
	logic [26:0]        x_q;
	logic [36:0]        x2_q;
	logic [46:0]        x3_q;
	logic [35:0]        k1_q;
	logic [DIV_W-1:0]   den_q;
	logic [24:0]        e_q;
	logic signed [24:0] c_q;
	logic signed [27:0] v_q;
	logic               gt_q;
	logic signed [39:0] s_q;
	logic signed [33:0] t_q;
	logic signed [39:0] n_q;
	logic signed [23:0] vn_q;
	logic signed [39:0] o_q;
	// output register
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;

	logic [15:0]              mn, mx, start_cl, base_goal, goal_new, size_base;
	logic signed [16:0]       size_diff;
	logic signed [PROD_W-1:0] g16, r16, r24, r_vn, o_fin;
	logic                     shoot;
	logic [15:0]              size_new;
	logic                     is_div;
	logic                     mul_start, div_start, mul_done, div_done;
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [DIV_W-1:0]         div_num, div_den, div_quo;

	// effective limits and goal update
	always_comb begin
		mn        = (min_q < MIN_FLOOR) ? MIN_FLOOR : min_q;
		mx        = (max_q < mn) ? mn : max_q;
		start_cl  = clamp_rng($signed({48'd0, start_q}), mn, mx);
		base_goal = started_q ? goal_q : start_cl;
		goal_new  = clamp_rng($signed({48'd0, base_goal}) - PROD_W'(zoom_q), mn, mx);
		size_base = started_q ? size_q : start_q;
		size_diff = $signed({1'b0, size_base}) - $signed({1'b0, goal_new});
		g16       = $signed({40'd0, goal_q, 8'd0});
	end

	// rounded products and final size
	always_comb begin
		r16      = rnd_sh(mul_p, 16);
		r24      = rnd_sh(mul_p, 24);
		r_vn     = rnd_sh(r24, 4);
		shoot    = gt_q == (PROD_W'(o_q) > g16);
		o_fin    = shoot ? g16 : PROD_W'(o_q);
		size_new = (st_q == '0) ? goal_q : clamp_rng(rnd_sh(o_fin, 8), mn, mx);
	end

	// operand selection for the shared units
	always_comb begin
		is_div  = (cmd.op == OP_W) || (cmd.op == OP_E);
		mul_a   = '0;
		mul_b   = '0;
		div_num = W_NUM + DIV_W'(st_q >> 1);
		div_den = DIV_W'(st_q);
		case (cmd.op)
			OP_X: begin
				mul_a = MUL_AW'($signed({1'b0, w_q}));
				mul_b = MUL_BW'($signed({1'b0, ts_q}));
			end
			OP_X2: begin
				mul_a = MUL_AW'($signed({1'b0, x_q}));
				mul_b = MUL_BW'($signed({1'b0, x_q}));
			end
			OP_X3: begin
				mul_a = MUL_AW'($signed({1'b0, x2_q}));
				mul_b = MUL_BW'($signed({1'b0, x_q}));
			end
			OP_K1: begin
				mul_a = MUL_AW'($signed({1'b0, x2_q}));
				mul_b = C048;
			end
			OP_DEN: begin
				mul_a = MUL_AW'($signed({1'b0, x3_q}));
				mul_b = C0235;
			end
			OP_E: begin
				div_num = E_NUM + (den_q >> 1);
				div_den = den_q;
			end
			OP_S: begin
				mul_a = MUL_AW'(c_q);
				mul_b = MUL_BW'($signed({1'b0, w_q}));
			end
			OP_T: begin
				mul_a = MUL_AW'(s_q);
				mul_b = MUL_BW'($signed({1'b0, ts_q}));
			end
			OP_N: begin
				mul_a = MUL_AW'(t_q);
				mul_b = MUL_BW'($signed({1'b0, w_q}));
			end
			OP_VN: begin
				mul_a = MUL_AW'(n_q);
				mul_b = MUL_BW'($signed({1'b0, e_q}));
			end
			OP_O: begin
				mul_a = MUL_AW'(PROD_W'(c_q) + PROD_W'(t_q));
				mul_b = MUL_BW'($signed({1'b0, e_q}));
			end
			default: begin
				mul_a = '0;
			end
		endcase
		mul_start = cmd.go && !is_div;
		div_start = cmd.go && is_div;
	end

	czs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.done   (mul_done)
	);

	czs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// configuration, persistent state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= 16'd26;
			max_q      <= 16'd25600;
			start_q    <= 16'd2560;
			st_q       <= 13'd1229;
			size_q     <= '0;
			goal_q     <= '0;
			speed_q    <= '0;
			started_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MIN:    min_q   <= cfg_data;
					CFG_MAX:    max_q   <= cfg_data;
					CFG_START:  start_q <= cfg_data;
					CFG_SMOOTH: st_q    <= cfg_data[12:0];
					default:    ;
				endcase
			end
			if (cmd.capture && cmd.op == OP_GOAL) begin
				goal_q    <= goal_new;
				size_q    <= size_base;
				started_q <= 1'b1;
			end
			if (cmd.finish) begin
				size_q     <= size_new;
				speed_q    <= (st_q == '0 || shoot) ? '0 : vn_q;
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// step registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zoom_q <= $signed(s_tdata[15:0]);
			ts_q   <= s_tdata[31:16];
		end
		if (cmd.finish)
			m_tdata_q <= {goal_q, size_new};
		if (cmd.capture) begin
			case (cmd.op)
				OP_GOAL: begin
					c_q  <= {size_diff, 8'd0};
					v_q  <= {speed_q, 4'd0};
					gt_q <= goal_new > size_base;
				end
				OP_W:   w_q  <= div_quo[29:0];
				OP_X:   x_q  <= (r16 > X_CAP) ? X_CAP[26:0] : r16[26:0];
				OP_X2:  x2_q <= r16[36:0];
				OP_X3:  x3_q <= r16[46:0];
				OP_K1:  k1_q <= r16[35:0];
				OP_DEN: den_q <= DIV_W'(ONE_Q16 + PROD_W'(x_q) + PROD_W'(k1_q) + r16);
				OP_E:   e_q  <= div_quo[24:0];
				OP_S:   s_q  <= 40'(PROD_W'(v_q) + r16);
				OP_T:   t_q  <= 34'(sat_sym(r16, T_LIM));
				OP_N:   n_q  <= 40'(sat_sym(PROD_W'(v_q) - r16, N_LIM));
				OP_VN:  vn_q <= (r_vn > VN_HI) ? VN_HI[23:0] :
						(r_vn < VN_LO) ? VN_LO[23:0] : r_vn[23:0];
				OP_O:   o_q  <= 40'(g16 + r24);
				default: ;
			endcase
		end
	end

	assign cfg_ready      = 1'b1;
	assign m_tvalid       = m_tvalid_q;
	assign m_tdata        = m_tdata_q;
	assign stat.unit_done = mul_done || div_done;
	assign stat.st_zero   = st_q == '0;
	assign stat.out_full  = m_tvalid_q && !m_tready;

endmodule

// File: tb/czs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czs_checker
// Watches the smoother's channels, predicts each output word and compares.
// ----------------------------------------------------------------------------
// Register writes and accepted input words drive a cycle-free copy of the
// smooth-damp filter. Its size and goal are queued per input word and checked
// field by field against every output word, in order.
module czs_checker
	import czs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          errors,
	output int          pending,
	output int          words_checked
);

	typedef struct {
		logic [15:0] size_now;
		logic [15:0] size_goal;
	} size_pair_t;

	// shadow registers and filter state
	logic [15:0] sh_min, sh_max, sh_start;
	logic [12:0] sh_smooth;
	longint      cur_size, cur_goal, cur_speed;
	bit          loaded;
	size_pair_t  expected_sizes[$];

	// divide by 2^sh, ties away from zero
	function automatic longint round_down(longint a, int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (a >= 0)
			return (a + half) >>> sh;
		return -((-a + half) >>> sh);
	endfunction

	function automatic longint limit_to(longint a, longint lo, longint hi);
		if (a < lo)
			return lo;
		if (a > hi)
			return hi;
		return a;
	endfunction

	// one filter update for an accepted word
	task automatic advance_size(logic signed [15:0] zoom, logic [15:0] dt);
		longint lo, hi, ts, w, x, x2, x3, den, e, c, v, s, t, n, vn, o, g16;
		size_pair_t r;
		lo = (sh_min < MIN_FLOOR) ? longint'(MIN_FLOOR) : longint'(sh_min);
		hi = (longint'(sh_max) < lo) ? lo : longint'(sh_max);
		ts = longint'(dt);
		if (!loaded) begin
			cur_size = sh_start;
			cur_goal = limit_to(sh_start, lo, hi);
			loaded = 1;
		end
		cur_goal = limit_to(cur_goal - longint'(zoom), lo, hi);
		if (sh_smooth == 0) begin
			cur_size = cur_goal;
			cur_speed = 0;
		end else begin
			w = ((longint'(1) << 29) + sh_smooth / 2) / sh_smooth;
			x = round_down(w * ts, 16);
			if (x > (longint'(1) << 26))
				x = longint'(1) << 26;
			x2 = round_down(x * x, 16);
			x3 = round_down(x2 * x, 16);
			den = 65536 + x + round_down(31457 * x2, 16) + round_down(15401 * x3, 16);
			e = ((longint'(1) << 40) + den / 2) / den;
			c = (cur_size - cur_goal) * 256;
			v = cur_speed * 16;
			s = v + round_down(w * c, 16);
			t = limit_to(round_down(s * ts, 16), -(longint'(1) << 32), longint'(1) << 32);
			n = limit_to(v - round_down(w * t, 16), -(longint'(1) << 38),
				longint'(1) << 38);
			vn = limit_to(round_down(round_down(n * e, 24), 4), -8388608, 8388607);
			g16 = cur_goal * 256;
			o = g16 + round_down((c + t) * e, 24);
			// overshoot clamp
			if ((cur_goal > cur_size) == (o > g16)) begin
				o = g16;
				vn = 0;
			end
			cur_speed = vn;
			cur_size = limit_to(round_down(o, 8), lo, hi);
		end
		r.size_now = cur_size[15:0];
		r.size_goal = cur_goal[15:0];
		expected_sizes.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		size_pair_t want;
		if (!arst_n) begin
			sh_min = 16'd26;
			sh_max = 16'd25600;
			sh_start = 16'd2560;
			sh_smooth = 13'd1229;
			cur_size = 0;
			cur_goal = 0;
			cur_speed = 0;
			loaded = 0;
			errors = 0;
			words_checked = 0;
			expected_sizes.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN: sh_min = cfg_data;
					CFG_MAX: sh_max = cfg_data;
					CFG_START: sh_start = cfg_data;
					CFG_SMOOTH: sh_smooth = cfg_data[12:0];
				endcase
			end
			// output word against oldest prediction
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (expected_sizes.size() == 0) begin
					$error("output word with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = expected_sizes.pop_front();
					if (m_tdata[15:0] !== want.size_now) begin
						$error("size_now expected %0d actual %0d", want.size_now,
							m_tdata[15:0]);
						errors++;
					end
					if (m_tdata[31:16] !== want.size_goal) begin
						$error("size_goal expected %0d actual %0d", want.size_goal,
							m_tdata[31:16]);
						errors++;
					end
				end
			end
			// input word
			if (s_tvalid && s_tready)
				advance_size(s_tdata[15:0], s_tdata[31:16]);
		end
		pending = expected_sizes.size();
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the critically damped zoom smoother.
// ----------------------------------------------------------------------------
// Runs directed corner words and then random phases under varied register
// settings, with random idle bursts on both streams. A separate checker
// predicts and compares every output word.
module tb_top;
	import czs_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_MIN;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	int          errors, pending, words_checked;
	int          words_sent = 0;
	int          idle_cycles = 0;
	int          rx_hold = 0;
	bit          calm = 0;

	always #5 clk = ~clk;

	critically_damped_zoom_smoother_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	czs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending), .words_checked(words_checked)
	);

	// receiver back-pressure in random bursts
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			m_tready <= 1;
			rx_hold <= 0;
		end else if (rx_hold > 1) begin
			rx_hold <= rx_hold - 1;
		end else if (rx_hold == 1) begin
			m_tready <= 1;
			rx_hold <= 0;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 0;
			rx_hold <= int'($urandom_range(1, 18));
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic send_step(logic [15:0] zoom, logic [15:0] dt);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {dt, zoom};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// drain outstanding words, then settle before touching registers
	task automatic wait_drained();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic load_regs(logic [15:0] mn, logic [15:0] mx, logic [15:0] st,
			logic [12:0] sm);
		write_reg(CFG_MIN, mn);
		write_reg(CFG_MAX, mx);
		write_reg(CFG_START, st);
		write_reg(CFG_SMOOTH, {3'b0, sm});
		cfg_valid <= 0;
	endtask

	// random words: mostly gentle zooms and frame-like time steps
	task automatic random_steps(int count);
		logic [15:0] zoom, dt;
		repeat (count) begin
			case ($urandom_range(0, 5))
				0: zoom = 16'($urandom);
				1: zoom = 16'($signed($urandom_range(0, 4000)) - 2000);
				default: zoom = 16'($signed($urandom_range(0, 512)) - 256);
			endcase
			case ($urandom_range(0, 4))
				0: dt = 16'($urandom);
				1: dt = 16'($urandom_range(0, 8));
				default: dt = 16'($urandom_range(500, 3000));
			endcase
			send_step(zoom, dt);
		end
	endtask

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// start size above the range, first word takes it unclamped
		load_regs(16'd0, 16'd25600, 16'hFFFF, 13'd1229);
		send_step(16'd0, 16'd1092);
		send_step(16'h8000, 16'd0);
		send_step(16'h7FFF, 16'hFFFF);
		send_step(16'hFFFF, 16'd1);
		send_step(16'd1, 16'hFFFF);
		send_step(16'h5555, 16'hAAAA);
		send_step(16'hAAAA, 16'h5555);
		wait_drained();

		// jump mode, max below min, tightest and loosest smoothing
		load_regs(16'd2000, 16'd100, 16'd0, 13'd0);
		send_step(16'h8000, 16'd1000);
		send_step(16'h7FFF, 16'd1000);
		wait_drained();
		load_regs(16'hFFFF, 16'hFFFF, 16'd0, 13'd1);
		send_step(16'h8000, 16'hFFFF);
		send_step(16'd0, 16'd0);
		wait_drained();
		load_regs(16'd26, 16'hFFFF, 16'd0, 13'h1FFF);
		send_step(16'h8000, 16'd0);
		send_step(16'h8000, 16'hFFFF);
		send_step(16'h7FFF, 16'd1);
		send_step(16'h7FFF, 16'd655);
		send_step(16'h1000, 16'd655);
		send_step(16'hF000, 16'd0);
		wait_drained();

		// random phases, extremes among the settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_regs(16'd26, 16'hFFFF, 16'd0, 13'd1);
				1: load_regs(16'd0, 16'd0, 16'd0, 13'd0);
				2: load_regs(16'd26, 16'd25600, 16'd0, 13'd1229);
				3: load_regs(16'd256, 16'd2560, 16'd0, 13'h1FFF);
				default: load_regs(16'($urandom_range(0, 3000)),
					16'($urandom_range(2000, 65535)), 16'($urandom),
					($urandom_range(0, 5) == 0) ? 13'd0 : 13'($urandom_range(1, 8191)));
			endcase
			if (ph == 7)
				calm = 1;
			random_steps(140);
			wait_drained();
		end

		repeat (200)
			@(posedge clk);
		$display("sent %0d steps, checked %0d output words over 12 register settings",
			words_sent, words_checked);
		$display("covered jump mode, range clamps, inverted limits and time step extremes");
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: critically_damped_zoom_smoother_unit.f
design/czs_pkg.sv
design/czs_div.sv
design/czs_mul.sv
design/czs_ctrl.sv
design/czs_dp.sv
design/critically_damped_zoom_smoother_unit.sv
tb/czs_checker.sv
tb/tb_top.sv
